>>> rtl/core/olvue_pkg.sv
// ----------------------------------------------------------------------------
// olvue_pkg
// Shared types, codes and helpers of the vector update engine.
// ----------------------------------------------------------------------------
package olvue_pkg;

	localparam int FRAC_BITS_DEF  = 32;
	localparam int DATA_WIDTH_DEF = 48;
	localparam int SUM_W          = 64;
	localparam int CFG_W          = 64;
	localparam int ADDR_W         = 4;

	// reset value of the denominator floor, about 1e-4 in Q16.32
	localparam logic [63:0] HD_MIN_RESET = 64'd429497;

	// register select, taken from paddr[3]
	localparam logic REG_ENERGY = 1'b0;
	localparam logic REG_HD_MIN = 1'b1;

	typedef enum logic [1:0] {
		FN_XY1    = 2'd0,
		FN_DENOM  = 2'd1,
		FN_UPDATE = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	// control tag that travels with each word down the pipe
	typedef struct packed {
		logic  valid;
		func_t func;
		logic  last;
		logic  neg;    // sign of the quotient
		logic  nneg;   // sign of the numerator
		logic  dzero;  // denominator is zero
		logic  nzero;  // numerator is zero
	} tag_t;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// saturating 64-bit add
	function automatic logic signed [SUM_W-1:0] sat_add64(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? SUM_MIN : SUM_MAX;
		end
		return s[SUM_W-1:0];
	endfunction

endpackage

>>> rtl/core/olvue_div_cell.sv
// ----------------------------------------------------------------------------
// olvue_div_cell
// One restoring-division step: shifts in one dividend bit, subtracts the
// denominator when it fits, and hands everything to the next cell.
// ----------------------------------------------------------------------------
module olvue_div_cell #(
	parameter int DW = olvue_pkg::DATA_WIDTH_DEF,
	parameter int NQ = olvue_pkg::DATA_WIDTH_DEF + olvue_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  olvue_pkg::tag_t      tag_i,
	input  logic [DW:0]          rem_i,
	input  logic [NQ-1:0]        dvd_i,
	input  logic [NQ-1:0]        quo_i,
	input  logic [DW:0]          dm_i,
	input  logic signed [DW-1:0] coef_i,
	input  logic signed [DW-1:0] corr_i,
	input  logic signed [DW-1:0] upd_i,
	output olvue_pkg::tag_t      tag_o,
	output logic [DW:0]          rem_o,
	output logic [NQ-1:0]        dvd_o,
	output logic [NQ-1:0]        quo_o,
	output logic [DW:0]          dm_o,
	output logic signed [DW-1:0] coef_o,
	output logic signed [DW-1:0] corr_o,
	output logic signed [DW-1:0] upd_o
);
	import olvue_pkg::*;

	localparam int RW = DW + 1;

	logic [RW:0]   trial;
	logic [RW:0]   dm_ext;
	logic          ge;
	logic [RW-1:0] rem_n;

	// trial subtract
	always_comb begin
		trial  = {rem_i, dvd_i[NQ-1]};
		dm_ext = {1'b0, dm_i};
		ge     = (trial >= dm_ext);
		rem_n  = ge ? RW'(trial - dm_ext) : trial[RW-1:0];
	end

	tag_t                 tag_q;
	logic [RW-1:0]        rem_q;
	logic [NQ-1:0]        dvd_q;
	logic [NQ-1:0]        quo_q;
	logic [DW:0]          dm_q;
	logic signed [DW-1:0] coef_q;
	logic signed [DW-1:0] corr_q;
	logic signed [DW-1:0] upd_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_i;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_n;
			dvd_q  <= {dvd_i[NQ-2:0], 1'b0};
			quo_q  <= {quo_i[NQ-2:0], ge};
			dm_q   <= dm_i;
			coef_q <= coef_i;
			corr_q <= corr_i;
			upd_q  <= upd_i;
		end
	end

	assign tag_o  = tag_q;
	assign rem_o  = rem_q;
	assign dvd_o  = dvd_q;
	assign quo_o  = quo_q;
	assign dm_o   = dm_q;
	assign coef_o = coef_q;
	assign corr_o = corr_q;
	assign upd_o  = upd_q;

endmodule

>>> rtl/core/olvue_mul_unit.sv
// ----------------------------------------------------------------------------
// olvue_mul_unit
// Two-stage signed fixed-point multiply: half-width partial products, then
// recombine, drop the fraction toward zero and saturate to 64 bits.
// ----------------------------------------------------------------------------
module olvue_mul_unit #(
	parameter int DW = olvue_pkg::DATA_WIDTH_DEF,
	parameter int F  = olvue_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] a,
	input  logic signed [DW-1:0] b,
	output logic signed [63:0]   prod
);
	import olvue_pkg::*;

	localparam int H  = (DW + 1) / 2;
	localparam int L  = DW - H;
	localparam int PW = 2 * DW;

	logic [DW-1:0] amag, bmag;
	logic          neg;

	always_comb begin
		amag = a[DW-1] ? DW'(-a) : DW'(a);
		bmag = b[DW-1] ? DW'(-b) : DW'(b);
		neg  = a[DW-1] ^ b[DW-1];
	end

	logic [2*H-1:0] pp_ll_s3;
	logic [H+L-1:0] pp_lh_s3, pp_hl_s3;
	logic [2*L-1:0] pp_hh_s3;
	logic           neg_s3;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s3 <= amag[H-1:0]  * bmag[H-1:0];
			pp_lh_s3 <= amag[H-1:0]  * bmag[DW-1:H];
			pp_hl_s3 <= amag[DW-1:H] * bmag[H-1:0];
			pp_hh_s3 <= amag[DW-1:H] * bmag[DW-1:H];
			neg_s3   <= neg;
		end
	end

	localparam logic [PW-1:0] LIM_P = PW'(64'h7fff_ffff_ffff_ffff);
	localparam logic [PW-1:0] LIM_N = PW'(64'h8000_0000_0000_0000);

	logic [PW-1:0]      full, shr;
	logic signed [63:0] prod_n;

	// recombine and saturate
	always_comb begin
		full = (PW'(pp_hh_s3) << (2 * H)) + (PW'(pp_lh_s3) << H)
			+ (PW'(pp_hl_s3) << H) + PW'(pp_ll_s3);
		shr  = full >> F;
		if (neg_s3) begin
			prod_n = (shr > LIM_N) ? SUM_MIN : -$signed(shr[63:0]);
		end else begin
			prod_n = (shr > LIM_P) ? SUM_MAX : $signed(shr[63:0]);
		end
	end

	logic signed [63:0] prod_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= prod_n;
		end
	end

	assign prod = prod_s4;

endmodule

>>> rtl/core/olvue_top_pipe.sv
// ----------------------------------------------------------------------------
// olvue_top_pipe
// Front end of the engine: denominator, clamp and numerator select, feeding
// the division chain.
// ----------------------------------------------------------------------------
module olvue_top_pipe #(
	parameter int DW = olvue_pkg::DATA_WIDTH_DEF,
	parameter int F  = olvue_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [1:0]           func,
	input  logic signed [DW-1:0] coef,
	input  logic signed [DW-1:0] diag,
	input  logic signed [DW-1:0] corr,
	input  logic                 last,
	input  logic signed [DW-1:0] energy,
	input  logic [DW-2:0]        hd_min,
	output olvue_pkg::tag_t      tag_s1,
	output logic [DW+F-1:0]      dvd_s1,
	output logic [DW:0]          dm_s1,
	output logic signed [DW-1:0] coef_s1,
	output logic signed [DW-1:0] corr_s1,
	output logic signed [DW-1:0] upd_s1
);
	import olvue_pkg::*;

	localparam logic signed [DW-1:0] EMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] EMIN = {1'b1, {(DW-1){1'b0}}};

	logic signed [DW:0]   d_full;
	logic [DW:0]          dmag, hd_ext, dm_sel;
	logic                 clamp, dneg;
	logic signed [DW-1:0] num;
	logic [DW-1:0]        nmag;
	logic signed [DW:0]   s;
	logic signed [DW-1:0] upd;
	func_t                fn;
	tag_t                 tag_n;

	// denominator with floor, numerator magnitude, update sum
	always_comb begin
		fn     = func_t'(func);
		d_full = {diag[DW-1], diag} - {energy[DW-1], energy};
		dmag   = d_full[DW] ? (~d_full + 1'b1) : d_full;
		hd_ext = {2'b00, hd_min};
		clamp  = (dmag < hd_ext);
		dm_sel = clamp ? hd_ext : dmag;
		dneg   = clamp ? 1'b0 : d_full[DW];
		num    = (fn == FN_XY1) ? coef : corr;
		nmag   = num[DW-1] ? DW'(-num) : DW'(num);
		s      = {coef[DW-1], coef} + {corr[DW-1], corr};
		if (s[DW] != s[DW-1]) begin
			upd = s[DW] ? EMIN : EMAX;
		end else begin
			upd = s[DW-1:0];
		end
		tag_n.valid = in_valid;
		tag_n.func  = fn;
		tag_n.last  = last;
		tag_n.neg   = num[DW-1] ^ dneg;
		tag_n.nneg  = num[DW-1];
		tag_n.dzero = (dm_sel == '0);
		tag_n.nzero = (nmag == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= tag_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s1  <= {nmag, {F{1'b0}}};
			dm_s1   <= dm_sel;
			coef_s1 <= coef;
			corr_s1 <= corr;
			upd_s1  <= upd;
		end
	end

endmodule

>>> rtl/core/olsen_vector_update_engine.sv
// ----------------------------------------------------------------------------
// olsen_vector_update_engine
// Streams vector elements through a chain of division cells, a split
// multiplier and saturating accumulators.
// ----------------------------------------------------------------------------
//  channel | signals                              | word
//  input   | in_valid, in_stall                   | func, coef, diag, corr, last
//  output  | out_valid, out_stall                 | elem_out, sum_*, sums_valid, last_out
//  config  | psel, penable, pwrite, paddr, pwdata | energy @0x0, hd_min @0x8
//
//  One word per cycle unless a stalled output holds the pipe. Words pass the front-end
//  register, a division chain of one cell per quotient bit, the saturation register,
//  two multiply stages and the accumulate/output register before out_valid rises.
//  Reset clears the pipe valids, the accumulators and energy, and sets hd_min to HD_MIN_RESET.
//  A stalled output freezes the whole pipe; in_stall is high while it does.
// ----------------------------------------------------------------------------
module olsen_vector_update_engine #(
	parameter int FRAC_BITS  = olvue_pkg::FRAC_BITS_DEF,
	parameter int DATA_WIDTH = olvue_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [olvue_pkg::ADDR_W-1:0] paddr,
	input  logic [olvue_pkg::CFG_W-1:0]  pwdata,
	output logic [olvue_pkg::CFG_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] coef,
	input  logic signed [DATA_WIDTH-1:0] diag,
	input  logic signed [DATA_WIDTH-1:0] corr,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] elem_out,
	output logic signed [63:0]           sum_one,
	output logic signed [63:0]           sum_two,
	output logic signed [63:0]           sum_three,
	output logic                         sums_valid,
	output logic                         last_out
);
	import olvue_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int NQ = DW + F;
	localparam logic signed [DW-1:0] EMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] EMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [NQ-1:0] QLIM_P = {{(NQ-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [NQ-1:0] QLIM_N = QLIM_P + 1'b1;

	logic en;
	logic out_valid_q;

	// pipe advances unless a held result is stalled
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// configuration registers
	logic signed [DW-1:0] energy_q;
	logic [DW-2:0]        hd_min_q;
	logic                 wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			hd_min_q <= (DW-1)'(HD_MIN_RESET);
		end else if (wr) begin
			if (paddr[3] == REG_ENERGY) begin
				energy_q <= pwdata[DW-1:0];
			end else begin
				hd_min_q <= pwdata[DW-2:0];
			end
		end
	end

	assign prdata = (paddr[3] == REG_HD_MIN) ? CFG_W'(hd_min_q) : CFG_W'(unsigned'(energy_q));

	// front end
	tag_t                 tag_c  [0:NQ];
	logic [DW:0]          rem_c  [0:NQ];
	logic [NQ-1:0]        dvd_c  [0:NQ];
	logic [NQ-1:0]        quo_c  [0:NQ];
	logic [DW:0]          dm_c   [0:NQ];
	logic signed [DW-1:0] coef_c [0:NQ];
	logic signed [DW-1:0] corr_c [0:NQ];
	logic signed [DW-1:0] upd_c  [0:NQ];

	olvue_top_pipe #(.DW(DW), .F(F)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.func    (func),
		.coef    (coef),
		.diag    (diag),
		.corr    (corr),
		.last    (last),
		.energy  (energy_q),
		.hd_min  (hd_min_q),
		.tag_s1  (tag_c[0]),
		.dvd_s1  (dvd_c[0]),
		.dm_s1   (dm_c[0]),
		.coef_s1 (coef_c[0]),
		.corr_s1 (corr_c[0]),
		.upd_s1  (upd_c[0])
	);

	assign rem_c[0] = '0;
	assign quo_c[0] = '0;

	// division chain, one quotient bit per cell
	for (genvar i = 0; i < NQ; i++) begin : g_cell
		olvue_div_cell #(.DW(DW), .NQ(NQ)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.tag_i (tag_c[i]),
			.rem_i (rem_c[i]),
			.dvd_i (dvd_c[i]),
			.quo_i (quo_c[i]),
			.dm_i  (dm_c[i]),
			.coef_i(coef_c[i]),
			.corr_i(corr_c[i]),
			.upd_i (upd_c[i]),
			.tag_o (tag_c[i+1]),
			.rem_o (rem_c[i+1]),
			.dvd_o (dvd_c[i+1]),
			.quo_o (quo_c[i+1]),
			.dm_o  (dm_c[i+1]),
			.coef_o(coef_c[i+1]),
			.corr_o(corr_c[i+1]),
			.upd_o (upd_c[i+1])
		);
	end

	// quotient saturation and element select
	tag_t                 tq;
	logic [NQ-1:0]        q;
	logic signed [DW-1:0] qdiv, elem_n;

	always_comb begin
		tq = tag_c[NQ];
		q  = quo_c[NQ];
		if (tq.dzero) begin
			qdiv = tq.nzero ? '0 : (tq.nneg ? EMIN : EMAX);
		end else if (tq.neg) begin
			qdiv = (q > QLIM_N) ? EMIN : -$signed(q[DW-1:0]);
		end else begin
			qdiv = (q > QLIM_P) ? EMAX : $signed(q[DW-1:0]);
		end
		unique case (tq.func)
			FN_XY1, FN_DENOM: elem_n = qdiv;
			FN_UPDATE:        elem_n = upd_c[NQ];
			default:          elem_n = '0;
		endcase
	end

	tag_t                 tag_s2, tag_s3, tag_s4;
	logic signed [DW-1:0] elem_s2, elem_s3, elem_s4;
	logic signed [DW-1:0] coef_s2, corr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (en) begin
			tag_s2 <= tq;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			elem_s2 <= elem_n;
			coef_s2 <= coef_c[NQ];
			corr_s2 <= corr_c[NQ];
			elem_s3 <= elem_s2;
			elem_s4 <= elem_s3;
		end
	end

	// products for the three sums
	logic signed [DW-1:0] ma1;
	logic signed [63:0]   p1, p2, p3;

	assign ma1 = (tag_s2.func == FN_UPDATE) ? elem_s2 : coef_s2;

	olvue_mul_unit #(.DW(DW), .F(F)) u_mul1 (
		.clk(clk), .en(en), .a(ma1), .b(elem_s2), .prod(p1)
	);
	olvue_mul_unit #(.DW(DW), .F(F)) u_mul2 (
		.clk(clk), .en(en), .a(elem_s2), .b(coef_s2), .prod(p2)
	);
	olvue_mul_unit #(.DW(DW), .F(F)) u_mul3 (
		.clk(clk), .en(en), .a(corr_s2), .b(corr_s2), .prod(p3)
	);

	// accumulate and output register
	logic signed [63:0] acc_one_q, acc_two_q, acc_three_q;
	logic signed [63:0] acc1_n, acc2_n, acc3_n;
	logic               add1, add23;

	always_comb begin
		add1   = (tag_s4.func == FN_XY1) || (tag_s4.func == FN_UPDATE);
		add23  = (tag_s4.func == FN_UPDATE);
		acc1_n = sat_add64(acc_one_q,   add1  ? p1 : 64'sd0);
		acc2_n = sat_add64(acc_two_q,   add23 ? p2 : 64'sd0);
		acc3_n = sat_add64(acc_three_q, add23 ? p3 : 64'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_one_q   <= '0;
			acc_two_q   <= '0;
			acc_three_q <= '0;
		end else if (en) begin
			out_valid_q <= tag_s4.valid;
			if (tag_s4.valid) begin
				acc_one_q   <= tag_s4.last ? 64'sd0 : acc1_n;
				acc_two_q   <= tag_s4.last ? 64'sd0 : acc2_n;
				acc_three_q <= tag_s4.last ? 64'sd0 : acc3_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && tag_s4.valid) begin
			elem_out   <= elem_s4;
			sum_one    <= tag_s4.last ? acc1_n : 64'sd0;
			sum_two    <= tag_s4.last ? acc2_n : 64'sd0;
			sum_three  <= tag_s4.last ? acc3_n : 64'sd0;
			sums_valid <= tag_s4.last;
			last_out   <= tag_s4.last;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(en && tag_s4.valid && tag_s4.last) |=>
			(acc_one_q == 0 && acc_two_q == 0 && acc_three_q == 0))
		else $error("accumulators not cleared after last word");

	a_sums_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_out) |->
			(sum_one == 0 && sum_two == 0 && sum_three == 0))
		else $error("partial sums shown on a non-final word");

	a_denom_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(en && tag_s4.valid && tag_s4.func == FN_DENOM && !tag_s4.last) |=>
			($stable(acc_one_q) && $stable(acc_two_q) && $stable(acc_three_q)))
		else $error("denominator word changed an accumulator");

endmodule
